// ===== design/min_gap_and_range_tracker_unit_macros.svh =====
// ----------------------------------------------------------------------------
// min_gap_and_range_tracker_unit_macros
// assertion shorthands for the checker file
// ----------------------------------------------------------------------------
`ifndef MIN_GAP_AND_RANGE_TRACKER_UNIT_MACROS_SVH
`define MIN_GAP_AND_RANGE_TRACKER_UNIT_MACROS_SVH

// same-cycle implication, sampled on clk, quiet while rst_n is low
`define MGRT_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, quiet while rst_n is low
`define MGRT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/mgrt_pkg.sv =====
// ----------------------------------------------------------------------------
// mgrt_pkg
// shared widths, constants and result layout of the gap and range tracker
// ----------------------------------------------------------------------------
`default_nettype none

package mgrt_pkg;

    localparam int DATA_W  = 32;
    localparam int CAP_W   = 11;
    localparam int GAP_W   = 31;
    localparam int SPAN_W  = 32;
    localparam int COUNT_W = 11;
    localparam int TDATA_W = 80;
    localparam int TUSER_W = 2;

    localparam logic [CAP_W-1:0] CAPACITY_RESET = 11'd1024;
    localparam logic [GAP_W-1:0] GAP_CLAMP      = 31'h7FFF_FFFF;

    // master tdata layout, lowest bits last
    typedef struct packed {
        logic [5:0]         pad;
        logic [SPAN_W-1:0]  longest_span;
        logic [GAP_W-1:0]   shortest_span;
        logic [COUNT_W-1:0] stored_count;
    } result_t;

    // master tuser layout
    typedef struct packed {
        logic spans_valid;
        logic status;
    } result_user_t;

endpackage

`default_nettype wire

// ===== design/mgrt_ram.sv =====
// ----------------------------------------------------------------------------
// mgrt_ram
// generic single-write, single-read memory with registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module mgrt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ===== design/min_gap_and_range_tracker_unit.sv =====
// ----------------------------------------------------------------------------
// min_gap_and_range_tracker_unit
// keeps a set of signed numbers and reports their closest gap and full range
// ----------------------------------------------------------------------------
// Numbers arrive one per transfer on the slave stream (s_tdata, signed).
// Each number is stored while the held count is below the capacity register
// (saturated at MAX_ENTRIES); otherwise it is turned away and the set stays.
// Every input transfer yields exactly one result transfer on the master
// stream: held count, smallest gap between any two held numbers (clamped at
// 2147483647), largest minus smallest, and flags for rejection and for
// two or more numbers held; both spans read zero below two numbers.
// The new number is compared with each held entry through a single memory
// read port and one shared subtract and compare path, one entry per cycle.
// A stored number passes through the scan, drain, update and done states;
// a rejected one goes straight to done, and the first one skips scan and
// drain; s_tready stays low meanwhile. The finished result sits in an
// output register, so the next number can be taken while the receiver
// stalls; a further result waits until that register has been taken.
// Reset empties the set, restores the capacity to 1024 and the gap to its
// clamp value; no clearing pass is needed. Capacity is written via cfg_we.
// ----------------------------------------------------------------------------
`default_nettype none

module min_gap_and_range_tracker_unit
    import mgrt_pkg::*;
#(
    parameter int MAX_ENTRIES = 1024
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    // configuration: capacity
    input  wire logic               cfg_we,
    input  wire logic [CAP_W-1:0]   cfg_wdata,
    // slave stream: [31:0] value
    input  wire logic               s_tvalid,
    output logic                    s_tready,
    input  wire logic [DATA_W-1:0]  s_tdata,
    // master stream
    output logic                    m_tvalid,
    input  wire logic               m_tready,
    // [10:0] stored_count, [41:11] shortest_span, [73:42] longest_span
    output logic [TDATA_W-1:0]      m_tdata,
    // [0] status, [1] spans_valid
    output logic [TUSER_W-1:0]      m_tuser
);

    localparam int ADDR_W = $clog2(MAX_ENTRIES);
    localparam int CNT_W  = $clog2(MAX_ENTRIES + 1);
    localparam int LIM_W  = (CNT_W > CAP_W) ? CNT_W : CAP_W;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_SCAN   = 3'd1;
    localparam logic [2:0] ST_DRAIN  = 3'd2;
    localparam logic [2:0] ST_UPDATE = 3'd3;
    localparam logic [2:0] ST_DONE   = 3'd4;

    logic [2:0]        state_reg, state_next;
    logic [CAP_W-1:0]  cap_reg, cap_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [CNT_W-1:0]  idx_reg, idx_next;
    logic              rd_valid_reg, rd_valid_next;
    logic              gap_valid_reg, gap_valid_next;
    logic [GAP_W-1:0]  best_reg, best_next;
    logic [DATA_W-1:0] min_reg, min_next;
    logic [DATA_W-1:0] max_reg, max_next;
    logic              m_tvalid_reg, m_tvalid_next;

    logic [DATA_W-1:0] value_reg, value_next;
    logic              reject_reg, reject_next;
    logic [DATA_W-1:0] gap_reg, gap_next;
    result_t           out_data_reg, out_data_next;
    result_user_t      out_user_reg, out_user_next;

    logic              s_xfer;
    logic              full;
    logic [LIM_W-1:0]  limit;
    logic              ram_we;
    logic              ram_re;
    logic [DATA_W-1:0] ram_rdata;
    logic              out_load;

    // value store
    mgrt_ram #(
        .WIDTH (DATA_W),
        .DEPTH (MAX_ENTRIES)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (count_reg[ADDR_W-1:0]),
        .wdata (value_reg),
        .re    (ram_re),
        .raddr (idx_reg[ADDR_W-1:0]),
        .rdata (ram_rdata)
    );

    // effective capacity and store-full test
    always_comb
    begin
        if (LIM_W'(cap_reg) > LIM_W'(MAX_ENTRIES))
        begin
            limit = LIM_W'(MAX_ENTRIES);
        end
        else
        begin
            limit = LIM_W'(cap_reg);
        end
        full = (LIM_W'(count_reg) >= limit);
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign s_xfer   = s_tvalid && s_tready;
    assign ram_re   = (state_reg == ST_SCAN);
    assign ram_we   = (state_reg == ST_UPDATE);
    assign out_load = (state_reg == ST_DONE) && (!m_tvalid_reg || m_tready);

    // sequencer
    always_comb
    begin
        state_next  = state_reg;
        idx_next    = idx_reg;
        count_next  = count_reg;
        min_next    = min_reg;
        max_next    = max_reg;
        value_next  = value_reg;
        reject_next = reject_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_xfer)
                begin
                    value_next  = s_tdata;
                    reject_next = full;
                    idx_next    = '0;
                    if (full)
                    begin
                        state_next = ST_DONE;
                    end
                    else if (count_reg == '0)
                    begin
                        state_next = ST_UPDATE;
                    end
                    else
                    begin
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                idx_next = idx_reg + 1'b1;
                if (idx_reg == count_reg - 1'b1)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (!rd_valid_reg && !gap_valid_reg)
                begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                count_next = count_reg + 1'b1;
                if (count_reg == '0)
                begin
                    min_next = value_reg;
                    max_next = value_reg;
                end
                else
                begin
                    if ($signed(value_reg) < $signed(min_reg))
                    begin
                        min_next = value_reg;
                    end
                    if ($signed(value_reg) > $signed(max_reg))
                    begin
                        max_next = value_reg;
                    end
                end
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // shared gap path: absolute difference, then compare with best
    always_comb
    begin
        rd_valid_next  = (state_reg == ST_SCAN);
        gap_valid_next = rd_valid_reg;
        gap_next       = gap_reg;
        best_next      = best_reg;
        if (rd_valid_reg)
        begin
            if ($signed(value_reg) >= $signed(ram_rdata))
            begin
                gap_next = value_reg - ram_rdata;
            end
            else
            begin
                gap_next = ram_rdata - value_reg;
            end
        end
        if (gap_valid_reg && (gap_reg < {1'b0, best_reg}))
        begin
            best_next = gap_reg[GAP_W-1:0];
        end
    end

    // configuration write
    always_comb
    begin
        cap_next = cap_reg;
        if (cfg_we)
        begin
            cap_next = cfg_wdata;
        end
    end

    // result register
    always_comb
    begin
        out_data_next = out_data_reg;
        out_user_next = out_user_reg;
        m_tvalid_next = m_tvalid_reg;
        if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
        if (out_load)
        begin
            m_tvalid_next              = 1'b1;
            out_user_next.status       = reject_reg;
            out_user_next.spans_valid  = (count_reg >= CNT_W'(2));
            out_data_next.pad          = '0;
            out_data_next.stored_count = COUNT_W'(count_reg);
            if (count_reg >= CNT_W'(2))
            begin
                out_data_next.shortest_span = best_reg;
                out_data_next.longest_span  = max_reg - min_reg;
            end
            else
            begin
                out_data_next.shortest_span = '0;
                out_data_next.longest_span  = '0;
            end
        end
    end

    // control and state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cap_reg       <= CAPACITY_RESET;
            count_reg     <= '0;
            idx_reg       <= '0;
            rd_valid_reg  <= 1'b0;
            gap_valid_reg <= 1'b0;
            best_reg      <= GAP_CLAMP;
            min_reg       <= '0;
            max_reg       <= '0;
            m_tvalid_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cap_reg       <= cap_next;
            count_reg     <= count_next;
            idx_reg       <= idx_next;
            rd_valid_reg  <= rd_valid_next;
            gap_valid_reg <= gap_valid_next;
            best_reg      <= best_next;
            min_reg       <= min_next;
            max_reg       <= max_next;
            m_tvalid_reg  <= m_tvalid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        value_reg    <= value_next;
        reject_reg   <= reject_next;
        gap_reg      <= gap_next;
        out_data_reg <= out_data_next;
        out_user_reg <= out_user_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

endmodule

`default_nettype wire

// ===== design/mgrt_checker.sv =====
// ----------------------------------------------------------------------------
// mgrt_checker
// port-level checks of the gap and range tracker, bound to its top level
// ----------------------------------------------------------------------------
`default_nettype none

`include "min_gap_and_range_tracker_unit_macros.svh"

module mgrt_checker
    import mgrt_pkg::*;
(
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               s_tvalid,
    input wire logic               s_tready,
    input wire logic               m_tvalid,
    input wire logic               m_tready,
    input wire logic [TDATA_W-1:0] m_tdata,
    input wire logic [TUSER_W-1:0] m_tuser
);

    result_t      res;
    result_user_t usr;

    assign res = m_tdata;
    assign usr = m_tuser;

    // a stalled result holds
    `MGRT_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result changed while stalled")

    // an accepted item keeps the input closed in the cycle after the transfer
    `MGRT_ASSERT_NEXT(a_busy_after_take, s_tvalid && s_tready, !s_tready, "input ready straight after a transfer")

    // spans read zero below two held numbers
    `MGRT_ASSERT_NOW(a_spans_zero, m_tvalid && !usr.spans_valid, (res.shortest_span == '0) && (res.longest_span == '0), "spans not zero below two numbers")

    // the closest gap never exceeds the full range
    `MGRT_ASSERT_NOW(a_gap_in_range, m_tvalid && usr.spans_valid, {1'b0, res.shortest_span} <= res.longest_span, "shortest span above longest span")

endmodule

bind min_gap_and_range_tracker_unit mgrt_checker u_mgrt_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire

// ===== tb/sv/min_gap_and_range_tracker_unit_test.sv =====
// ----------------------------------------------------------------------------
// min_gap_and_range_tracker_unit_test
// self-checking bench for the gap and range tracker
// ----------------------------------------------------------------------------
// Numbers go in on the slave stream in bursts with random gaps, while the
// receiver stalls on its own pattern. A behavioural copy of the set works
// out the expected report for every accepted number and keeps it in a queue.
// Each report on the master stream is checked field by field against the
// oldest entry. Directed tests cover the value extremes, capacity zero and
// one, a capacity dropped below the count, and duplicates. A random fill then
// grows the set through many capacity settings, and a final phase runs with
// the largest capacity, well above the store depth.
// ----------------------------------------------------------------------------
`default_nettype none

module min_gap_and_range_tracker_unit_test;

    timeunit 1ns;
    timeprecision 1ps;

    import mgrt_pkg::*;

    localparam int          MAX_ENTRIES = 1024;
    localparam int unsigned CYCLE_LIMIT = 4_000_000;
    localparam int          FILL_TARGET = 512;
    localparam logic        ST_STORED   = 1'b0;
    localparam logic        ST_REJECTED = 1'b1;
    localparam logic [CAP_W-1:0] CAP_TOP = 11'd2047;

    // one expected report
    typedef struct {
        logic               status;
        logic [COUNT_W-1:0] stored_count;
        logic               spans_valid;
        logic [GAP_W-1:0]   shortest_span;
        logic [SPAN_W-1:0]  longest_span;
    } span_report_t;

    logic               clk;
    logic               rst_n;
    logic               cfg_we;
    logic [CAP_W-1:0]   cfg_wdata;
    logic               s_tvalid;
    logic               s_tready;
    logic [DATA_W-1:0]  s_tdata;
    logic               m_tvalid;
    logic               m_tready;
    logic [TDATA_W-1:0] m_tdata;
    logic [TUSER_W-1:0] m_tuser;

    // behavioural copy of the set
    logic [DATA_W-1:0]  set_vals [MAX_ENTRIES];
    int unsigned        set_count;
    logic [DATA_W-1:0]  set_lo;
    logic [DATA_W-1:0]  set_hi;
    logic [31:0]        best_gap;
    logic [CAP_W-1:0]   set_capacity;

    span_report_t       pending_reports [$];

    int unsigned        cycle_count;
    int unsigned        mismatches;
    int unsigned        reports_checked;
    int unsigned        values_sent;
    int unsigned        values_rejected;
    int                 burst_left;
    logic [DATA_W-1:0]  cluster_base;

    min_gap_and_range_tracker_unit #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    // clock
    initial clk = 1'b0;
    always #5 clk = ~clk;

    // run limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d reports outstanding",
                     cycle_count, pending_reports.size());
            $display("min_gap_and_range_tracker_unit regression: fail");
            $finish;
        end
    end

    // predict the report for one accepted number and update the set
    function automatic span_report_t add_to_set(input logic [DATA_W-1:0] v);
        span_report_t rep;
        int unsigned  limit;
        logic [31:0]  g;
        limit = (set_capacity > MAX_ENTRIES) ? MAX_ENTRIES : set_capacity;
        if (set_count >= limit)
        begin
            rep.status = ST_REJECTED;
        end
        else
        begin
            rep.status = ST_STORED;
            for (int i = 0; i < set_count; i++)
            begin
                g = ($signed(v) >= $signed(set_vals[i])) ? v - set_vals[i]
                                                         : set_vals[i] - v;
                if (g < best_gap)
                    best_gap = g;
            end
            if (set_count == 0)
            begin
                set_lo = v;
                set_hi = v;
            end
            else
            begin
                if ($signed(v) < $signed(set_lo))
                    set_lo = v;
                if ($signed(v) > $signed(set_hi))
                    set_hi = v;
            end
            set_vals[set_count] = v;
            set_count++;
        end
        rep.stored_count = set_count[COUNT_W-1:0];
        rep.spans_valid  = (set_count >= 2);
        rep.shortest_span = (set_count >= 2) ? best_gap[GAP_W-1:0] : '0;
        rep.longest_span  = (set_count >= 2) ? set_hi - set_lo : '0;
        return rep;
    endfunction

    // mismatch reporting, first ten in full
    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch on %s at report %0d: expected 0x%08h, got 0x%08h",
                         name, reports_checked, want, got);
        end
    endtask

    // report checker
    always @(posedge clk)
    begin
        result_t      r;
        result_user_t u;
        span_report_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            r = m_tdata;
            u = m_tuser;
            if (pending_reports.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("report transfer with nothing outstanding: tdata 0x%020h",
                             m_tdata);
            end
            else
            begin
                want = pending_reports.pop_front();
                check_field("status", 32'(want.status), 32'(u.status));
                check_field("stored_count", 32'(want.stored_count),
                            32'(r.stored_count));
                check_field("spans_valid", 32'(want.spans_valid), 32'(u.spans_valid));
                check_field("shortest_span", 32'(want.shortest_span),
                            32'(r.shortest_span));
                check_field("longest_span", want.longest_span, r.longest_span);
            end
            reports_checked++;
        end
    end

    // receiver stall pattern in four randomly chosen modes
    always @(posedge clk)
    begin
        int unsigned rx_mode;
        int unsigned rx_left;
        if (rx_left == 0)
        begin
            rx_mode = $urandom_range(0, 3);
            rx_left = $urandom_range(8, 80);
        end
        rx_left--;
        case (rx_mode)
            0:       m_tready <= 1'b1;
            1:       m_tready <= 1'($urandom_range(0, 1));
            2:       m_tready <= ($urandom_range(0, 3) == 0);
            default: m_tready <= ($urandom_range(0, 15) == 0);
        endcase
    end

    // send one number, predict its report, then keep the burst or pause
    task automatic send_value(input logic [DATA_W-1:0] v);
        span_report_t rep;
        s_tvalid <= 1'b1;
        s_tdata  <= v;
        do
            @(posedge clk);
        while (!s_tready);
        rep = add_to_set(v);
        pending_reports = {pending_reports, rep};
        values_sent++;
        if (rep.status == ST_REJECTED)
            values_rejected++;
        if (burst_left <= 0)
        begin
            s_tvalid <= 1'b0;
            if ($urandom_range(0, 7) == 0)
                repeat ($urandom_range(7, 60)) @(posedge clk);
            else
                repeat ($urandom_range(1, 6)) @(posedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(0, 10);
        end
        else
        begin
            burst_left--;
        end
    endtask

    // stop sending and wait for every outstanding report
    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending_reports.size() != 0)
            @(posedge clk);
        @(posedge clk);
    endtask

    // capacity write, only with the block idle
    task automatic write_capacity(input logic [CAP_W-1:0] c);
        drain();
        cfg_we    <= 1'b1;
        cfg_wdata <= c;
        @(posedge clk);
        cfg_we    <= 1'b0;
        set_capacity = c;
    endtask

    // mostly spread-out numbers, some in a cluster
    function automatic logic [DATA_W-1:0] next_value();
        if ($urandom_range(0, 15) == 0)
            cluster_base = $urandom;
        if ($urandom_range(0, 9) < 7)
            return $urandom;
        return cluster_base + $urandom_range(0, 32'h00FF_FFFF);
    endfunction

    task automatic test_reset_capacity();
        send_value(32'h7FFF_FFFF);
    endtask

    task automatic test_capacity_zero();
        write_capacity(11'd0);
        send_value(32'h8000_0000);
        send_value(32'h0000_0000);
    endtask

    task automatic test_capacity_one();
        write_capacity(11'd1);
        send_value(32'h0000_0005);
    endtask

    // both extremes held: full range and a gap past the clamp
    task automatic test_extremes();
        write_capacity(11'd2);
        send_value(32'h8000_0000);
        send_value(32'h0000_0001);
        write_capacity(11'd5);
        send_value(32'h0000_0000);
        send_value(32'h4000_0000);
        send_value(32'hC000_0000);
    endtask

    task automatic test_capacity_below_count();
        write_capacity(11'd3);
        send_value(32'h0000_0007);
        send_value(32'h1234_5678);
    endtask

    // grow the set through many capacity settings
    task automatic test_random_fill();
        int unsigned step;
        int unsigned extra;
        logic [CAP_W-1:0] c;
        while (set_count < FILL_TARGET)
        begin
            step  = $urandom_range(1, 48);
            if (step > FILL_TARGET - set_count)
                step = FILL_TARGET - set_count;
            extra = 0;
            case ($urandom_range(0, 9))
                0:
                begin
                    c     = CAP_W'($urandom_range(0, set_count));
                    step  = 0;
                    extra = $urandom_range(1, 4);
                end
                1:
                begin
                    c = CAP_W'($urandom_range(set_count + step, CAP_TOP));
                end
                default:
                begin
                    c     = CAP_W'(set_count + step);
                    extra = $urandom_range(0, 3);
                end
            endcase
            write_capacity(c);
            repeat (step + extra)
                send_value(next_value());
            // now and then a full drain on top of the capacity writes
            if ($urandom_range(0, 7) == 0)
                drain();
        end
    endtask

    // a close neighbour, an exact repeat, then a neighbour that is turned away
    task automatic test_duplicates();
        logic [DATA_W-1:0] v;
        v = set_vals[$urandom_range(0, set_count - 1)];
        write_capacity(CAP_W'(set_count + 2));
        send_value(v + 32'd1);
        send_value(v);
        send_value(v - 32'd1);
    endtask

    // largest capacity, above the store depth, then back to the reset value
    task automatic test_capacity_saturation();
        write_capacity(CAP_TOP);
        repeat (16)
            send_value(next_value());
        write_capacity(CAPACITY_RESET);
        send_value(32'h7FFF_FFFE);
    endtask

    initial
    begin
        rst_n       = 1'b0;
        cfg_we      = 1'b0;
        cfg_wdata   = '0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        set_count   = 0;
        set_lo      = '0;
        set_hi      = '0;
        best_gap    = {1'b0, GAP_CLAMP};
        set_capacity = CAPACITY_RESET;
        burst_left  = 0;
        cluster_base = $urandom;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_capacity();
        test_capacity_zero();
        test_capacity_one();
        test_extremes();
        test_capacity_below_count();
        test_random_fill();
        test_duplicates();
        test_capacity_saturation();

        drain();
        repeat (20) @(posedge clk);

        $display("sent %0d numbers (%0d turned away), %0d reports checked, %0d cycles",
                 values_sent, values_rejected, reports_checked, cycle_count);
        $display("capacities from 0 to 2047 used, store filled to %0d entries",
                 set_count);
        if (mismatches == 0 && pending_reports.size() == 0)
            $display("min_gap_and_range_tracker_unit regression: pass");
        else
            $display("min_gap_and_range_tracker_unit regression: fail");
        $finish;
    end

endmodule

`default_nettype wire
